// ===== src/afs_pkg.sv =====
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and constants of the alarm and fan supervisor.
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int unsigned MODULE_COUNT = 8;
  localparam int unsigned ALARM_W      = 32;
  localparam int unsigned TEMP_W       = 12;
  localparam int unsigned HYST_W       = 11;
  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic signed [TEMP_W-1:0] FAN_ON_THRESHOLD_RST = 12'sd640;
  localparam logic [HYST_W-1:0]        FAN_HYSTERESIS_RST   = 11'd80;
  localparam logic [PERIOD_W-1:0]      BLINK_PERIOD_RST     = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAN_ON_THRESHOLD = 2'd0,
    CFG_FAN_HYSTERESIS   = 2'd1,
    CFG_BLINK_PERIOD     = 2'd2
  } afs_cfg_e;

  typedef enum logic [3:0] {
    OP_TICK         = 4'd0,
    OP_MODULE_ALARM = 4'd1,
    OP_DETAIL_BIT   = 4'd2,
    OP_UNIT_BIT     = 4'd3,
    OP_DETAIL_MASK  = 4'd4,
    OP_UNIT_MASK    = 4'd5,
    OP_GLOBAL_MASK  = 4'd6,
    OP_FAN_MANUAL   = 4'd7,
    OP_FAN_AUTO     = 4'd8
  } afs_op_e;

  // one alarm edit handed to the alarm bank
  typedef struct packed {
    logic               fire;
    logic [3:0]         operation;
    logic [4:0]         module_index;
    logic [4:0]         bit_position;
    logic               set_value;
    logic [ALARM_W-1:0] mask_word;
  } afs_cmd_t;

  // alarm state as it stands after the edit
  typedef struct packed {
    logic [ALARM_W-1:0] global_alarms;
    logic               alarm_active;
    logic [ALARM_W-1:0] module_detail;
    logic [ALARM_W-1:0] module_units;
  } afs_view_t;

endpackage

// ===== src/afs_alarm_bank.sv =====
// ----------------------------------------------------------------------------
// afs_alarm_bank
// Global alarm mask plus per-module detail and unit masks, with the
// module summary kept in the global mask.
// ----------------------------------------------------------------------------
module afs_alarm_bank import afs_pkg::*; #(
  parameter int unsigned ModuleCount = MODULE_COUNT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  afs_cmd_t  cmd_i,
  output afs_view_t view_o
);

  logic [ALARM_W-1:0] alarm_q, alarm_d;
  logic [ALARM_W-1:0] detail_q [ModuleCount];
  logic [ALARM_W-1:0] detail_d [ModuleCount];
  logic [ALARM_W-1:0] unit_q   [ModuleCount];
  logic [ALARM_W-1:0] unit_d   [ModuleCount];

  logic [ALARM_W-1:0] bit_mask;
  logic [ALARM_W-1:0] sel_detail, sel_units, all_masks;
  logic               in_range, module_op;
  afs_op_e            op;

  assign op        = afs_op_e'(cmd_i.operation);
  assign bit_mask  = ALARM_W'(1) << cmd_i.bit_position;
  assign in_range  = {1'b0, cmd_i.module_index} < 6'(ModuleCount);
  assign module_op = (op inside {OP_DETAIL_BIT, OP_UNIT_BIT, OP_DETAIL_MASK, OP_UNIT_MASK});

  always_comb begin
    for (int i = 0; i < ModuleCount; i++) begin
      detail_d[i] = detail_q[i];
      unit_d[i]   = unit_q[i];
      if (cmd_i.fire && (cmd_i.module_index == 5'(i))) begin
        case (op)
          OP_DETAIL_BIT:  detail_d[i] = cmd_i.set_value ? (detail_q[i] | bit_mask)
                                                         : (detail_q[i] & ~bit_mask);
          OP_UNIT_BIT:    unit_d[i]   = cmd_i.set_value ? (unit_q[i] | bit_mask)
                                                         : (unit_q[i] & ~bit_mask);
          OP_DETAIL_MASK: detail_d[i] = cmd_i.mask_word;
          OP_UNIT_MASK:   unit_d[i]   = cmd_i.mask_word;
          default: ;
        endcase
      end
    end
  end

  // addressed module read and the or over every mask
  always_comb begin
    sel_detail = '0;
    sel_units  = '0;
    all_masks  = '0;
    for (int i = 0; i < ModuleCount; i++) begin
      if (cmd_i.module_index == 5'(i)) begin
        sel_detail = detail_d[i];
        sel_units  = unit_d[i];
      end
      all_masks = all_masks | detail_d[i] | unit_d[i];
    end
  end

  always_comb begin
    alarm_d = alarm_q;
    if (cmd_i.fire) begin
      case (op)
        OP_MODULE_ALARM: alarm_d[cmd_i.module_index] = cmd_i.set_value;
        OP_GLOBAL_MASK:  alarm_d = cmd_i.mask_word;
        default: ;
      endcase
      if (module_op && in_range) begin
        alarm_d[cmd_i.module_index] = |(sel_detail | sel_units);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= '0;
      for (int i = 0; i < ModuleCount; i++) begin
        detail_q[i] <= '0;
        unit_q[i]   <= '0;
      end
    end else begin
      alarm_q <= alarm_d;
      for (int i = 0; i < ModuleCount; i++) begin
        detail_q[i] <= detail_d[i];
        unit_q[i]   <= unit_d[i];
      end
    end
  end

  assign view_o.global_alarms = alarm_d;
  assign view_o.alarm_active  = |(alarm_d | all_masks);
  assign view_o.module_detail = sel_detail;
  assign view_o.module_units  = sel_units;

endmodule

// ===== src/alarm_and_fan_supervisor_top.sv =====
// ----------------------------------------------------------------------------
// alarm_and_fan_supervisor_top
// Fan hysteresis control and alarm LED blinking over a bank of alarm masks.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is one operation: a one millisecond tick that may carry
//   board and clock-chip temperatures, an alarm mask edit, or a fan mode
//   change. Every accepted word returns exactly one result word with the fan
//   and LED state, the global alarm mask, the any-alarm flag and the masks of
//   the addressed module, all taken after the operation is applied.
//   An accepted word waits in the input register and is applied as it moves
//   into the result register. Throughput is one word per cycle while results
//   are taken; the input register and result register form a two-deep
//   pipeline, so a new word is taken while a result waits. When the receiver
//   holds out_ready_i low the result stays put, the input register fills, and
//   then in_ready_o drops until the result is taken. Reset clears all
//   temperatures, masks, the millisecond counter, the LED and the fan and
//   selects automatic fan mode; configuration registers return to their
//   defaults. Configuration written through cfg_we_i takes effect at once; the
//   user must write it only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
module alarm_and_fan_supervisor_top import afs_pkg::*; #(
  parameter int unsigned ModuleCount = MODULE_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [3:0]                  operation_i,
  input  logic [4:0]                  module_index_i,
  input  logic [4:0]                  bit_position_i,
  input  logic                        set_value_i,
  input  logic [ALARM_W-1:0]          mask_word_i,
  input  logic signed [TEMP_W-1:0]    board_sample_i,
  input  logic                        board_present_i,
  input  logic signed [TEMP_W-1:0]    clock_sample_i,
  input  logic                        clock_present_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        fan_drive_o,
  output logic                        led_drive_o,
  output logic [ALARM_W-1:0]          global_alarms_o,
  output logic                        alarm_active_o,
  output logic [ALARM_W-1:0]          module_detail_o,
  output logic [ALARM_W-1:0]          module_units_o
);

  // configuration registers
  logic signed [TEMP_W-1:0] thresh_q;
  logic [HYST_W-1:0]        hyst_q;
  logic [PERIOD_W-1:0]      period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= FAN_ON_THRESHOLD_RST;
      hyst_q   <= FAN_HYSTERESIS_RST;
      period_q <= BLINK_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (afs_cfg_e'(cfg_index_i))
        CFG_FAN_ON_THRESHOLD: thresh_q <= cfg_data_i[TEMP_W-1:0];
        CFG_FAN_HYSTERESIS:   hyst_q   <= cfg_data_i[HYST_W-1:0];
        CFG_BLINK_PERIOD:     period_q <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_q, out_valid_q;
  logic out_free, s1_adv, in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (out_free)   out_valid_q <= s1_valid_q;
    end
  end

  // input register
  logic [3:0]               op_q;
  logic [4:0]               mod_q, pos_q;
  logic                     setv_q;
  logic [ALARM_W-1:0]       word_q;
  logic signed [TEMP_W-1:0] bsample_q, csample_q;
  logic                     bpresent_q, cpresent_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= operation_i;
      mod_q      <= module_index_i;
      pos_q      <= bit_position_i;
      setv_q     <= set_value_i;
      word_q     <= mask_word_i;
      bsample_q  <= board_sample_i;
      bpresent_q <= board_present_i;
      csample_q  <= clock_sample_i;
      cpresent_q <= clock_present_i;
    end
  end

  // alarm masks
  afs_cmd_t  cmd;
  afs_view_t view;

  assign cmd.fire         = s1_adv;
  assign cmd.operation    = op_q;
  assign cmd.module_index = mod_q;
  assign cmd.bit_position = pos_q;
  assign cmd.set_value    = setv_q;
  assign cmd.mask_word    = word_q;

  afs_alarm_bank #(
    .ModuleCount (ModuleCount)
  ) u_alarm_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .view_o (view)
  );

  // fan, temperature and LED state
  logic signed [TEMP_W-1:0] btemp_q, btemp_d, ctemp_q, ctemp_d, hot;
  logic                     bvalid_q, bvalid_d, cvalid_q, cvalid_d;
  logic                     fan_q, fan_d, manual_q, manual_d, led_q, led_d;
  logic [ALARM_W-1:0]       time_q, time_d, deadline_q, deadline_d, since;
  logic signed [TEMP_W:0]   off_level;
  logic                     have_temp, is_tick;
  afs_op_e                  op;

  assign op        = afs_op_e'(op_q);
  assign is_tick   = s1_adv && (op == OP_TICK);
  assign off_level = {thresh_q[TEMP_W-1], thresh_q} - $signed({2'b00, hyst_q});
  assign since     = time_q - deadline_q;

  always_comb begin
    btemp_d    = btemp_q;
    bvalid_d   = bvalid_q;
    ctemp_d    = ctemp_q;
    cvalid_d   = cvalid_q;
    fan_d      = fan_q;
    manual_d   = manual_q;
    led_d      = led_q;
    time_d     = time_q;
    deadline_d = deadline_q;

    if (is_tick) begin
      if (bpresent_q) begin
        btemp_d  = bsample_q;
        bvalid_d = 1'b1;
      end
      if (cpresent_q) begin
        ctemp_d  = csample_q;
        cvalid_d = 1'b1;
      end
    end

    // higher of the valid temperatures
    have_temp = bvalid_d || cvalid_d;
    hot       = (cvalid_d && (!bvalid_d || (ctemp_d > btemp_d))) ? ctemp_d : btemp_d;

    if (is_tick) begin
      if (!manual_q && have_temp) begin
        if (!fan_q && (hot >= thresh_q)) begin
          fan_d = 1'b1;
        end else if (fan_q && ($signed({hot[TEMP_W-1], hot}) <= off_level)) begin
          fan_d = 1'b0;
        end
      end
      if (!view.alarm_active) begin
        led_d = 1'b0;
      end else if (!since[ALARM_W-1]) begin
        // deadline reached, wrapping compare
        led_d      = !led_q;
        deadline_d = time_q + ALARM_W'(period_q);
      end
      time_d = time_q + ALARM_W'(1);
    end

    if (s1_adv) begin
      case (op)
        OP_FAN_MANUAL: begin
          manual_d = 1'b1;
          fan_d    = setv_q;
        end
        OP_FAN_AUTO: manual_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btemp_q    <= '0;
      bvalid_q   <= 1'b0;
      ctemp_q    <= '0;
      cvalid_q   <= 1'b0;
      fan_q      <= 1'b0;
      manual_q   <= 1'b0;
      led_q      <= 1'b0;
      time_q     <= '0;
      deadline_q <= '0;
    end else begin
      btemp_q    <= btemp_d;
      bvalid_q   <= bvalid_d;
      ctemp_q    <= ctemp_d;
      cvalid_q   <= cvalid_d;
      fan_q      <= fan_d;
      manual_q   <= manual_d;
      led_q      <= led_d;
      time_q     <= time_d;
      deadline_q <= deadline_d;
    end
  end

  // result register
  logic               res_fan_q, res_led_q, res_active_q;
  logic [ALARM_W-1:0] res_global_q, res_detail_q, res_units_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_fan_q    <= fan_d;
      res_led_q    <= led_d;
      res_global_q <= view.global_alarms;
      res_active_q <= view.alarm_active;
      res_detail_q <= view.module_detail;
      res_units_q  <= view.module_units;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fan_drive_o     = res_fan_q;
  assign led_drive_o     = res_led_q;
  assign global_alarms_o = res_global_q;
  assign alarm_active_o  = res_active_q;
  assign module_detail_o = res_detail_q;
  assign module_units_o  = res_units_q;

endmodule
